### rtl/chtm_pkg.sv
// shared types, codes and helpers for the convex hull trick minimum core
`default_nettype none
package chtm_pkg;

  localparam int HULL_DEPTH_DEF = 1024;
  localparam int SLOPE_W        = 32;
  localparam int ICPT_W         = 62;
  localparam int LINE_W         = SLOPE_W + ICPT_W;

  typedef enum logic [1:0] {
    K_INS  = 2'd0,
    K_BS   = 2'd1,
    K_MQ   = 2'd2,
    K_NONE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_INS   = 3'd1,
    ST_EMPTY = 3'd2,
    ST_FULL  = 3'd3,
    ST_ORDER = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BACK_ADDR,
    S_BACK,
    S_POP_CHK,
    S_PAIR0,
    S_PAIR1,
    S_PAIR2,
    S_SETUP,
    S_CMP,
    S_INS_WR,
    S_BS_CHK,
    S_MQ_CHK,
    S_EV_ADDR,
    S_EV_DATA,
    S_EV_SUM,
    S_DONE
  } state_t;

  function automatic logic [63:0] sx62(input logic [ICPT_W-1:0] v);
    return {{(64 - ICPT_W){v[ICPT_W-1]}}, v};
  endfunction

  function automatic logic [31:0] slope_diff(input logic [SLOPE_W-1:0] hi_s,
                                             input logic [SLOPE_W-1:0] lo_s);
    logic [SLOPE_W:0] d;
    d = {hi_s[SLOPE_W-1], hi_s} - {lo_s[SLOPE_W-1], lo_s};
    return d[31:0];
  endfunction

endpackage
`default_nettype wire

### rtl/monotone_convex_hull_trick_min_core.sv
// convex hull trick (monotone slopes, minimum) core with ring-buffer line store
// insert: p crossing checks and q back pops before the line is written; none on an empty hull
// binary query: s checks, s <= ceil(log2(count)); monotone query: c checks
// order error, drop, empty query, kind 3: no checks; check = pair read, setup, 4 mul
// one item in flight; in_tready is low until the result is in the output register
// rst_n (synchronous, active low) empties the hull; line store contents are not cleared
`default_nettype none
module monotone_convex_hull_trick_min_core #(
  parameter int HULL_DEPTH = chtm_pkg::HULL_DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,  // slope[31:0], intercept[93:32], query_point[125:94]
  input  wire logic [1:0]   in_tuser,  // kind[1:0]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic      [63:0]  out_tdata, // value[63:0]
  output logic      [2:0]   out_tuser  // status[2:0]
);
  import chtm_pkg::*;

  localparam int IW = $clog2(HULL_DEPTH);     // slot index width
  localparam int CW = $clog2(HULL_DEPTH + 1); // line count width

  // control
  state_t          state_r, state_nxt;
  logic [1:0]      kind_r, kind_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [IW-1:0]   front_r, front_nxt;
  logic [CW-1:0]   n_r, n_nxt;     // working line count during insert
  logic [CW-1:0]   lo_r, lo_nxt;
  logic [CW-1:0]   hi_r, hi_nxt;
  logic [CW-1:0]   mid_r, mid_nxt;
  logic [CW-1:0]   i_r, i_nxt;     // first index of the line pair being read
  logic [2:0]      ph_r, ph_nxt;   // compare phase
  logic            out_valid_r, out_valid_nxt;

  // payload
  logic [31:0]     a_r, a_nxt;
  logic [61:0]     b_r, b_nxt;
  logic [31:0]     x_r, x_nxt;
  logic [31:0]     l0a_r, l0a_nxt, l1a_r, l1a_nxt;
  logic [61:0]     l0b_r, l0b_nxt, l1b_r, l1b_nxt;
  logic [63:0]     u1_r, u1_nxt, u2_r, u2_nxt;
  logic [31:0]     d1_r, d1_nxt, d2_r, d2_nxt;
  logic [97:0]     acc_r, acc_nxt;
  logic [65:0]     p_r;
  logic [63:0]     val_r, val_nxt;
  logic [2:0]      stat_r, stat_nxt;
  logic [63:0]     out_data_r, out_data_nxt;
  logic [2:0]      out_stat_r, out_stat_nxt;

  // shared multiplier operands
  logic [32:0]     ma, mb;
  logic [65:0]     prod;
  logic [97:0]     p_ext;

  // line store
  logic            we;
  logic [IW-1:0]   waddr, raddr;
  logic [LINE_W-1:0] rdata;
  logic [31:0]     rd_a;
  logic [61:0]     rd_b;

  logic [CW:0]     lohi;

  // ring slot of logical index i
  function automatic logic [IW-1:0] slot(input logic [CW-1:0] i);
    logic [CW:0] s;
    s = (CW+1)'(front_r) + (CW+1)'(i);
    if (s >= (CW+1)'(HULL_DEPTH)) begin
      s = s - (CW+1)'(HULL_DEPTH);
    end
    return s[IW-1:0];
  endfunction

  chtm_ram #(.WIDTH(LINE_W), .DEPTH(HULL_DEPTH)) u_lines (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata ({a_r, b_r}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_a = rdata[LINE_W-1:ICPT_W];
  assign rd_b = rdata[ICPT_W-1:0];

  // signed operands are extended to the full 66-bit product width
  assign prod  = $signed(ma) * $signed(mb);
  assign p_ext = {{32{p_r[65]}}, p_r};
  assign lohi  = (CW+1)'(lo_r) + (CW+1)'(hi_r);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      front_r     <= '0;
      out_valid_r <= 1'b0;
      ph_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      front_r     <= front_nxt;
      out_valid_r <= out_valid_nxt;
      ph_r        <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    n_r        <= n_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    i_r        <= i_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    x_r        <= x_nxt;
    l0a_r      <= l0a_nxt;
    l0b_r      <= l0b_nxt;
    l1a_r      <= l1a_nxt;
    l1b_r      <= l1b_nxt;
    u1_r       <= u1_nxt;
    u2_r       <= u2_nxt;
    d1_r       <= d1_nxt;
    d2_r       <= d2_nxt;
    acc_r      <= acc_nxt;
    p_r        <= prod;
    val_r      <= val_nxt;
    stat_r     <= stat_nxt;
    out_data_r <= out_data_nxt;
    out_stat_r <= out_stat_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    count_nxt     = count_r;
    front_nxt     = front_r;
    n_nxt         = n_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    i_nxt         = i_r;
    ph_nxt        = ph_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    x_nxt         = x_r;
    l0a_nxt       = l0a_r;
    l0b_nxt       = l0b_r;
    l1a_nxt       = l1a_r;
    l1b_nxt       = l1b_r;
    u1_nxt        = u1_r;
    u2_nxt        = u2_r;
    d1_nxt        = d1_r;
    d2_nxt        = d2_r;
    acc_nxt       = acc_r;
    val_nxt       = val_r;
    stat_nxt      = stat_r;
    out_data_nxt  = out_data_r;
    out_stat_nxt  = out_stat_r;
    out_valid_nxt = out_valid_r && !out_tready;
    ma            = '0;
    mb            = '0;
    we            = 1'b0;
    waddr         = slot(n_r);
    raddr         = slot(i_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt = in_tuser;
          a_nxt    = in_tdata[31:0];
          b_nxt    = in_tdata[93:32];
          x_nxt    = in_tdata[125:94];
          n_nxt    = count_r;
          val_nxt  = '0;
          stat_nxt = ST_OK;
          case (kind_t'(in_tuser)) inside
            K_INS: begin
              state_nxt = (count_r == '0) ? S_INS_WR : S_BACK_ADDR;
            end
            K_BS, K_MQ: begin
              if (count_r == '0) begin
                stat_nxt  = ST_EMPTY;
                state_nxt = S_DONE;
              end else begin
                lo_nxt    = '0;
                hi_nxt    = count_r;
                state_nxt = (kind_t'(in_tuser) == K_BS) ? S_BS_CHK : S_MQ_CHK;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_BACK_ADDR: begin
        raddr     = slot(n_r - CW'(1));
        state_nxt = S_BACK;
      end

      S_BACK: begin
        if ($signed(a_r) > $signed(rd_a)) begin
          stat_nxt  = ST_ORDER;
          state_nxt = S_DONE;
        end else if (a_r == rd_a && $signed(rd_b) <= $signed(b_r)) begin
          stat_nxt  = ST_INS;   // same slope, not lower: dropped
          state_nxt = S_DONE;
        end else begin
          if (a_r == rd_a) begin
            n_nxt = n_r - CW'(1);
          end
          state_nxt = S_POP_CHK;
        end
      end

      S_POP_CHK: begin
        if (n_r > CW'(1)) begin
          i_nxt     = n_r - CW'(2);
          state_nxt = S_PAIR0;
        end else begin
          state_nxt = S_INS_WR;
        end
      end

      S_PAIR0: begin
        raddr     = slot(i_r);
        state_nxt = S_PAIR1;
      end

      S_PAIR1: begin
        raddr     = slot(i_r + CW'(1));
        l0a_nxt   = rd_a;
        l0b_nxt   = rd_b;
        state_nxt = S_PAIR2;
      end

      S_PAIR2: begin
        l1a_nxt   = rd_a;
        l1b_nxt   = rd_b;
        state_nxt = S_SETUP;
      end

      S_SETUP: begin
        u1_nxt = sx62(l1b_r) - sx62(l0b_r);
        d1_nxt = slope_diff(l0a_r, l1a_r);
        if (kind_t'(kind_r) == K_INS) begin
          u2_nxt = sx62(b_r) - sx62(l1b_r);
          d2_nxt = slope_diff(l1a_r, a_r);
        end else begin
          u2_nxt = {{32{x_r[31]}}, x_r};
          d2_nxt = 32'd1;
        end
        ph_nxt    = '0;
        state_nxt = S_CMP;
      end

      // sign of u1*d2 - u2*d1 built from four 33x33 partial products
      S_CMP: begin
        ph_nxt = ph_r + 3'd1;
        case (ph_r)
          3'd0: begin
            ma      = {1'b0, u1_r[31:0]};
            mb      = {1'b0, d2_r};
            acc_nxt = '0;
          end
          3'd1: begin
            ma      = {u1_r[63], u1_r[63:32]};
            mb      = {1'b0, d2_r};
            acc_nxt = acc_r + p_ext;
          end
          3'd2: begin
            ma      = {1'b0, u2_r[31:0]};
            mb      = {1'b0, d1_r};
            acc_nxt = acc_r + (p_ext << 32);
          end
          3'd3: begin
            ma      = {u2_r[63], u2_r[63:32]};
            mb      = {1'b0, d1_r};
            acc_nxt = acc_r - p_ext;
          end
          3'd4: begin
            acc_nxt = acc_r - (p_ext << 32);
          end
          default: begin
            ph_nxt = '0;
            case (kind_t'(kind_r))
              K_INS: begin
                if (acc_r[97]) begin
                  state_nxt = S_INS_WR;
                end else begin
                  n_nxt     = n_r - CW'(1);
                  state_nxt = S_POP_CHK;
                end
              end
              K_BS: begin
                if (acc_r[97]) lo_nxt = mid_r;
                else           hi_nxt = mid_r;
                state_nxt = S_BS_CHK;
              end
              default: begin
                if (acc_r[97]) begin
                  front_nxt = (front_r == IW'(HULL_DEPTH - 1)) ? '0 : front_r + IW'(1);
                  count_nxt = count_r - CW'(1);
                  state_nxt = S_MQ_CHK;
                end else begin
                  lo_nxt    = '0;
                  state_nxt = S_EV_ADDR;
                end
              end
            endcase
          end
        endcase
      end

      S_INS_WR: begin
        if (n_r >= CW'(HULL_DEPTH)) begin
          stat_nxt = ST_FULL;
        end else begin
          we        = 1'b1;
          count_nxt = n_r + CW'(1);
          stat_nxt  = ST_INS;
        end
        state_nxt = S_DONE;
      end

      S_BS_CHK: begin
        if ((CW+1)'(lo_r) + (CW+1)'(1) < (CW+1)'(hi_r)) begin
          mid_nxt   = lohi[CW:1];
          i_nxt     = lohi[CW:1] - CW'(1);
          state_nxt = S_PAIR0;
        end else begin
          state_nxt = S_EV_ADDR;
        end
      end

      S_MQ_CHK: begin
        if (count_r > CW'(1)) begin
          i_nxt     = '0;
          state_nxt = S_PAIR0;
        end else begin
          lo_nxt    = '0;
          state_nxt = S_EV_ADDR;
        end
      end

      S_EV_ADDR: begin
        raddr     = slot(lo_r);
        state_nxt = S_EV_DATA;
      end

      S_EV_DATA: begin
        ma        = {rd_a[31], rd_a};
        mb        = {x_r[31], x_r};
        l0b_nxt   = rd_b;
        state_nxt = S_EV_SUM;
      end

      S_EV_SUM: begin
        val_nxt   = p_r[63:0] + sx62(l0b_r);
        stat_nxt  = ST_OK;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = val_r;
          out_stat_nxt  = stat_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### rtl/chtm_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module chtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/chtm_checker.sv
// port-level checker for the convex hull trick core, bound to the top level
`default_nettype none
module chtm_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [63:0]  out_tdata,
  input wire logic [2:0]   out_tuser
);
  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // an accepted item keeps the block busy in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken twice in a row");

  // status codes stay in range
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= 3'd4))
    else $error("bad status code");

  // inserts and errors carry a zero value
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != 3'd0) |-> (out_tdata == 64'd0))
    else $error("nonzero value with non-query status");
endmodule

bind monotone_convex_hull_trick_min_core chtm_checker u_chtm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

### bench/monotone_convex_hull_trick_min_core_tb.sv
// testbench for the monotone convex hull trick minimum core, with its own hull predictor
`timescale 1ns / 100ps
`default_nettype none
module monotone_convex_hull_trick_min_core_tb;
  import chtm_pkg::*;

  localparam int DEPTH     = 64;
  localparam int EXP_DEPTH = 16;
  localparam int STALL_MAX = 60000;
  localparam longint SLOPE_MAX = 64'sd2147483647;
  localparam longint SLOPE_MIN = -64'sd2147483648;
  localparam longint ICPT_MAX  = 64'sd2305843009213693951;
  localparam longint ICPT_MIN  = -64'sd2305843009213693952;

  typedef struct packed {
    logic [63:0] value;
    status_t     status;
  } hull_result_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;  // slope[31:0], intercept[93:32], query_point[125:94]
  logic [1:0]   in_tuser;  // kind[1:0]
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata; // value[63:0]
  logic [2:0]   out_tuser; // status[2:0]

  monotone_convex_hull_trick_min_core #(.HULL_DEPTH(DEPTH)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // predicted hull: ring of lines in decreasing slope order
  longint       line_slope [DEPTH];
  longint       line_icpt  [DEPTH];
  int unsigned  hull_front;
  int unsigned  hull_count;
  // expected results: written by the sender, read by the checker
  hull_result_t exp_store [EXP_DEPTH];
  int unsigned  exp_wr;
  int unsigned  exp_rd = 0;
  int           fail_count = 0;
  bit           idle_enable;
  longint       cross_mark;   // last crossing built by the convex insert generator
  longint       query_mark;   // mostly rising x for monotone queries

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  function automatic int unsigned ring_slot(int unsigned i);
    return (hull_front + i) % DEPTH;
  endfunction

  // exact n1/d1 < n2/d2 with positive denominators
  function automatic bit ratio_below(longint n1, longint d1, longint n2, longint d2);
    logic signed [127:0] lhs, rhs, f;
    lhs = n1; f = d2; lhs = lhs * f;
    rhs = n2; f = d1; rhs = rhs * f;
    return lhs < rhs;
  endfunction

  // crossing of line i with line i+1 lies left of x
  function automatic bit crossing_left_of(int unsigned i, longint x);
    int unsigned s0, s1;
    s0 = ring_slot(i);
    s1 = ring_slot(i + 1);
    return ratio_below(line_icpt[s1] - line_icpt[s0], line_slope[s0] - line_slope[s1], x, 1);
  endfunction

  function automatic longint line_value(int unsigned i, longint x);
    int unsigned s;
    s = ring_slot(i);
    return line_slope[s] * x + line_icpt[s];
  endfunction

  function automatic status_t add_line(longint a, longint b);
    int unsigned n, s0, s1, bs;
    n = hull_count;
    if (n > 0) begin
      bs = ring_slot(n - 1);
      if (a > line_slope[bs]) return ST_ORDER;
      if (a == line_slope[bs]) begin
        if (line_icpt[bs] <= b) return ST_INS;
        n--;
      end
    end
    while (n > 1) begin
      s0 = ring_slot(n - 2);
      s1 = ring_slot(n - 1);
      if (ratio_below(line_icpt[s1] - line_icpt[s0], line_slope[s0] - line_slope[s1],
                      b - line_icpt[s1], line_slope[s1] - a))
        break;
      n--;
    end
    if (n >= DEPTH) return ST_FULL;
    line_slope[ring_slot(n)] = a;
    line_icpt[ring_slot(n)]  = b;
    hull_count = n + 1;
    return ST_INS;
  endfunction

  function automatic hull_result_t hull_answer(kind_t kind, longint a, longint b, longint x);
    hull_result_t r;
    int unsigned lo, hi, mid;
    r.value  = '0;
    r.status = ST_OK;
    if (kind == K_INS) begin
      r.status = add_line(a, b);
    end else if (kind == K_BS || kind == K_MQ) begin
      if (hull_count == 0) begin
        r.status = ST_EMPTY;
      end else if (kind == K_BS) begin
        lo = 0; hi = hull_count;
        while (lo + 1 < hi) begin
          mid = (lo + hi) >> 1;
          if (crossing_left_of(mid - 1, x)) lo = mid;
          else hi = mid;
        end
        r.value = line_value(lo, x);
      end else begin
        while (hull_count > 1 && crossing_left_of(0, x)) begin
          hull_front = (hull_front + 1) % DEPTH;
          hull_count--;
        end
        r.value = line_value(0, x);
      end
    end
    return r;
  endfunction

  // present one item, wait for its handshake, then predict its result
  task automatic send_item(kind_t kind, longint a, longint b, longint x);
    @(negedge clk);
    while (idle_enable && $urandom_range(0, 99) < 7) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {2'b00, x[31:0], b[61:0], a[31:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    exp_store[exp_wr % EXP_DEPTH] = hull_answer(kind, a, b, x);
    exp_wr++;
  endtask

  // drop the input and hold off until every expected result has come
  task automatic wait_for_results;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (exp_rd != exp_wr) @(posedge clk);
  endtask

  function automatic longint rand_icpt();
    logic [61:0] v;
    v = 62'({$urandom, $urandom});
    return longint'($signed(v));
  endfunction

  function automatic longint rand_x();
    return longint'($signed($urandom));
  endfunction

  // result side: random stalls, compare, watchdog
  int idle_cycles;
  always @(negedge clk) begin
    out_tready <= !(idle_enable && $urandom_range(0, 99) < 7);
  end

  always @(posedge clk) begin
    hull_result_t exp_r;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_rd == exp_wr) begin
        $display("%0t unexpected item: value %h status %0d", $time, out_tdata, out_tuser);
        fail_count++;
      end else begin
        exp_r = exp_store[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (out_tdata !== exp_r.value) begin
          $display("%0t value mismatch: expected %h actual %h", $time, exp_r.value, out_tdata);
          fail_count++;
        end
        if (out_tuser !== exp_r.status) begin
          $display("%0t status mismatch: expected %0d actual %0d", $time, exp_r.status,
                   out_tuser);
          fail_count++;
        end
      end
    end
  end

  // empty hull queries, unknown kind, slope extremes, replace and drop, order error
  task automatic test_directed;
    send_item(K_BS, 0, 0, 0);
    send_item(K_MQ, 0, 0, SLOPE_MAX);
    send_item(K_NONE, -1, -1, -1);
    send_item(K_INS, SLOPE_MAX, ICPT_MAX, SLOPE_MIN);
    send_item(K_INS, SLOPE_MAX, 0, 0);
    send_item(K_INS, SLOPE_MAX, 5, 0);
    send_item(K_INS, 1000, ICPT_MIN, 0);
    send_item(K_INS, 2000, 0, 0);
    send_item(K_INS, 0, 0, 0);
    send_item(K_BS, 0, 0, SLOPE_MIN);
    send_item(K_BS, 0, 0, SLOPE_MAX);
    send_item(K_BS, 0, 0, 0);
    send_item(K_MQ, 0, 0, SLOPE_MIN);
    send_item(K_MQ, 0, 0, 0);
    send_item(K_MQ, 0, 0, SLOPE_MAX);
  endtask

  // fill the ring until an insert is refused, with no idling on either side
  task automatic test_full_hull;
    longint i;
    idle_enable = 1'b0;
    i = 1;
    while (i < 1200) begin
      send_item(K_INS, -i, i * i, rand_x());
      if (exp_store[(exp_wr - 1) % EXP_DEPTH].status == ST_FULL) break;
      i++;
    end
    send_item(K_INS, -i - 1, ICPT_MAX, 0);
    for (int k = 0; k < 4; k++) send_item(K_BS, 0, 0, rand_x());
    idle_enable = 1'b1;
    // hold off until the hull is quiet, then collapse it to one line
    wait_for_results();
    send_item(K_MQ, 0, 0, SLOPE_MAX);
    cross_mark = 0;
    query_mark = 0;
  endtask

  // mostly convex, well-ordered inserts mixed with both query kinds and some noise
  task automatic test_random_mix(int n_items);
    int r;
    longint back_a, back_b, a, b, c;
    for (int k = 0; k < n_items; k++) begin
      r = $urandom_range(0, 99);
      back_a = line_slope[ring_slot(hull_count - 1)];
      back_b = line_icpt[ring_slot(hull_count - 1)];
      if (r < 50) begin
        r = $urandom_range(0, 99);
        if (r < 6 && back_a < SLOPE_MAX) begin
          a = back_a + $urandom_range(1, 1000);
          if (a > SLOPE_MAX) a = SLOPE_MAX;
          b = rand_icpt();
        end else if (r < 16 || back_a - (1 << 21) < SLOPE_MIN) begin
          a = back_a;
          b = ($urandom_range(0, 1) == 1) ? back_b - $urandom_range(1, 100) : rand_icpt();
        end else if (r < 70) begin
          a = back_a - $urandom_range(1, 1 << 21);
          c = cross_mark + $urandom_range(1, 1000);
          cross_mark = c;
          b = back_b + (back_a - a) * c;
        end else begin
          a = back_a - $urandom_range(1, 1 << 21);
          b = rand_icpt();
        end
        // keep the intercept inside its field
        if (b > ICPT_MAX) b = ICPT_MAX;
        if (b < ICPT_MIN) b = ICPT_MIN;
        send_item(K_INS, a, b, rand_x());
      end else if (r < 72) begin
        send_item(K_BS, rand_icpt(), rand_icpt(),
                  ($urandom_range(0, 3) == 0) ? rand_x()
                                              : longint'($urandom_range(0, 2000))
                                                + cross_mark - 1000);
      end else if (r < 95) begin
        if ($urandom_range(0, 9) == 0) query_mark = rand_x();
        else query_mark = query_mark + $urandom_range(0, 600);
        if (query_mark > SLOPE_MAX) query_mark = SLOPE_MAX;
        send_item(K_MQ, rand_icpt(), rand_icpt(), query_mark);
      end else begin
        send_item(K_NONE, rand_icpt(), rand_icpt(), rand_x());
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = K_NONE;
    idle_enable = 1'b1;
    exp_wr      = 0;
    hull_front  = 0;
    hull_count  = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_hull();
    test_random_mix(660);
    wait_for_results();
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
